// ===== rtl/refcounted_buffer_pool_allocator_defines.svh =====
// Assertion macros shared by the buffer pool allocator RTL.
`ifndef REFCOUNTED_BUFFER_POOL_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_BUFFER_POOL_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define RBPA_ASSERT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> post) \
    else $error("rbpa assertion failed");

// Next-cycle implication.
`define RBPA_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> post) \
    else $error("rbpa assertion failed");

`endif

// ===== rtl/rbpa_pkg.sv =====
// Types and constants of the buffer pool allocator.
package rbpa_pkg;

  localparam int OBJECTS    = 16;
  localparam int PROCESSES  = 8;
  localparam int COUNT_BITS = 16;

  localparam int OBJ_W  = $clog2(OBJECTS);
  localparam int PID_W  = $clog2(PROCESSES);
  localparam int FCNT_W = $clog2(OBJECTS + 1);
  localparam int WCNT_W = $clog2(PROCESSES + 1);
  localparam int CMD_W  = 3;
  localparam int AMT_W  = 8;
  localparam int STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_REQ     = 3'd0,
    CMD_REL     = 3'd1,
    CMD_ADD     = 3'd2,
    CMD_ENABLE  = 3'd3,
    CMD_DISABLE = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_REL_FREE = 2'd1,
    ST_DROP     = 2'd2
  } status_t;

  typedef struct packed {
    logic                  cmd_we;
    logic [OBJ_W-1:0]      cmd_idx;
    logic [COUNT_BITS-1:0] live_new;
    logic                  allow_we;
    logic                  allow_val;
    logic                  set_free;
    logic                  grant_we;
    logic [OBJ_W-1:0]      grant_idx;
  } obj_wr_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [OBJ_W-1:0] val;
  } free_op_t;

  typedef struct packed {
    logic             push;
    logic             pop;
    logic [PID_W-1:0] val;
  } wait_op_t;

endpackage

// ===== rtl/rbpa_obj_table.sv =====
// Per-object live count, release enable and free flag.
module rbpa_obj_table (
  input  logic                           clk,
  input  logic                           rst,
  input  rbpa_pkg::obj_wr_t              wr,
  input  logic [rbpa_pkg::OBJ_W-1:0]     rd_idx,
  output logic [rbpa_pkg::COUNT_BITS-1:0] rd_live,
  output logic                           rd_allow,
  output logic                           rd_free
);
  import rbpa_pkg::*;

  logic [COUNT_BITS-1:0] live_count [OBJECTS];
  logic [OBJECTS-1:0]    release_allowed;
  logic [OBJECTS-1:0]    is_free;

  assign rd_live  = live_count[rd_idx];
  assign rd_allow = release_allowed[rd_idx];
  assign rd_free  = is_free[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < OBJECTS; i++) begin
        live_count[i] <= '0;
      end
      release_allowed <= '1;
      is_free         <= '1;
    end else begin
      if (wr.cmd_we) begin
        live_count[wr.cmd_idx] <= wr.live_new;
      end
      if (wr.allow_we) begin
        release_allowed[wr.cmd_idx] <= wr.allow_val;
      end
      if (wr.set_free) begin
        is_free[wr.cmd_idx] <= 1'b1;
      end
      // grant wins over the command on the same object
      if (wr.grant_we) begin
        live_count[wr.grant_idx]      <= '0;
        release_allowed[wr.grant_idx] <= 1'b1;
        is_free[wr.grant_idx]         <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/rbpa_deques.sv =====
// Free-object deque and waiting-process deque, front push and front pop.
module rbpa_deques (
  input  logic                         clk,
  input  logic                         rst,
  input  rbpa_pkg::free_op_t           free_op,
  input  rbpa_pkg::wait_op_t           wait_op,
  output logic [rbpa_pkg::FCNT_W-1:0]  free_count,
  output logic [rbpa_pkg::OBJ_W-1:0]   free_front,
  output logic [rbpa_pkg::WCNT_W-1:0]  waiter_count,
  output logic [rbpa_pkg::PID_W-1:0]   waiter_front
);
  import rbpa_pkg::*;
  `include "refcounted_buffer_pool_allocator_defines.svh"

  logic [OBJ_W-1:0] free_ring [OBJECTS];
  logic [OBJ_W-1:0] free_head;
  logic [OBJ_W-1:0] free_head_dec;
  logic [PID_W-1:0] waiter_ring [PROCESSES];
  logic [PID_W-1:0] waiter_head;
  logic [PID_W-1:0] waiter_head_dec;

  assign free_front      = free_ring[free_head];
  assign waiter_front    = waiter_ring[waiter_head];
  assign free_head_dec   = (free_head == '0) ? OBJ_W'(OBJECTS - 1) : free_head - 1'b1;
  assign waiter_head_dec = (waiter_head == '0) ? PID_W'(PROCESSES - 1)
                                               : waiter_head - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < OBJECTS; i++) begin
        free_ring[i] <= OBJ_W'(i);
      end
      free_head  <= '0;
      free_count <= FCNT_W'(OBJECTS);
    end else if (free_op.push && !free_op.pop) begin
      free_ring[free_head_dec] <= free_op.val;
      free_head                <= free_head_dec;
      free_count               <= free_count + 1'b1;
    end else if (free_op.pop && !free_op.push) begin
      free_head  <= (free_head == OBJ_W'(OBJECTS - 1)) ? '0 : free_head + 1'b1;
      free_count <= free_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wait_op.push && !wait_op.pop) begin
      waiter_ring[waiter_head_dec] <= wait_op.val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiter_head  <= '0;
      waiter_count <= '0;
    end else if (wait_op.push && !wait_op.pop) begin
      waiter_head  <= waiter_head_dec;
      waiter_count <= waiter_count + 1'b1;
    end else if (wait_op.pop && !wait_op.push) begin
      waiter_head  <= (waiter_head == PID_W'(PROCESSES - 1)) ? '0 : waiter_head + 1'b1;
      waiter_count <= waiter_count - 1'b1;
    end
  end

  `RBPA_ASSERT(free_count_bound, 1'b1, free_count <= FCNT_W'(OBJECTS))
  `RBPA_ASSERT(waiter_count_bound, 1'b1, waiter_count <= WCNT_W'(PROCESSES))
  `RBPA_ASSERT(no_idle_match, 1'b1, free_count == '0 || waiter_count == '0)
  `RBPA_ASSERT(free_pop_nonempty, free_op.pop && !free_op.push, free_count != '0)
endmodule

// ===== rtl/refcounted_buffer_pool_allocator.sv =====
// Top level: command register, single-pass update of pool state, result register.
// A command taken into the command register gives its result strobe (done) from the result register.
// Throughput: one command per cycle; busy stays low.
// Reset (rst, synchronous): all objects free in order 0..15, no waiters,
// counts zero, releases enabled; no strobe during or right after reset.
// Results cannot be stalled: each is shown for one cycle only.
module refcounted_buffer_pool_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [rbpa_pkg::CMD_W-1:0]    cmd,
  input  logic [rbpa_pkg::PID_W-1:0]    process_id,
  input  logic [rbpa_pkg::OBJ_W-1:0]    object_id,
  input  logic [rbpa_pkg::AMT_W-1:0]    amount,
  output logic                          done,
  output logic                          grant_valid,
  output logic [rbpa_pkg::OBJ_W-1:0]    grant_object,
  output logic [rbpa_pkg::PID_W-1:0]    grant_process,
  output logic [rbpa_pkg::STAT_W-1:0]   status
);
  import rbpa_pkg::*;
  `include "refcounted_buffer_pool_allocator_defines.svh"

  logic                  v_q;
  logic [CMD_W-1:0]      cmd_q;
  logic [PID_W-1:0]      pid_q;
  logic [OBJ_W-1:0]      obj_q;
  logic [AMT_W-1:0]      amt_q;

  logic [COUNT_BITS-1:0] rd_live;
  logic                  rd_allow;
  logic                  rd_free;
  logic [FCNT_W-1:0]     free_count;
  logic [OBJ_W-1:0]      free_front;
  logic [WCNT_W-1:0]     waiter_count;
  logic [PID_W-1:0]      waiter_front;

  obj_wr_t               wr;
  free_op_t              free_op;
  wait_op_t              wait_op;

  logic                  is_req, is_rel, is_add;
  logic                  push_wait, push_free, grant;
  logic [COUNT_BITS-1:0] live_dec;
  logic [COUNT_BITS:0]   live_sum;
  logic [OBJ_W-1:0]      g_obj;
  logic [PID_W-1:0]      g_pid;
  status_t               st_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= 1'b0;
    end else begin
      v_q <= start;
    end
    if (start) begin
      cmd_q <= cmd;
      pid_q <= process_id;
      obj_q <= object_id;
      amt_q <= amount;
    end
  end

  rbpa_obj_table u_obj_table (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_idx   (obj_q),
    .rd_live  (rd_live),
    .rd_allow (rd_allow),
    .rd_free  (rd_free)
  );

  rbpa_deques u_deques (
    .clk          (clk),
    .rst          (rst),
    .free_op      (free_op),
    .wait_op      (wait_op),
    .free_count   (free_count),
    .free_front   (free_front),
    .waiter_count (waiter_count),
    .waiter_front (waiter_front)
  );

  always_comb begin
    is_req    = v_q && (cmd_q == CMD_REQ);
    is_rel    = v_q && (cmd_q == CMD_REL);
    is_add    = v_q && (cmd_q == CMD_ADD);
    live_dec  = (rd_live != '0) ? rd_live - 1'b1 : '0;
    live_sum  = {1'b0, rd_live} + (COUNT_BITS + 1)'(amt_q);
    push_wait = is_req && (waiter_count != WCNT_W'(PROCESSES));
    push_free = is_rel && !rd_free && rd_allow && (live_dec == '0) &&
                (free_count < FCNT_W'(OBJECTS));
    grant     = (free_count != '0 || push_free) && (waiter_count != '0 || push_wait);
    g_obj     = push_free ? obj_q : free_front;
    g_pid     = push_wait ? pid_q : waiter_front;

    priority if (is_req && !push_wait) begin
      st_next = ST_DROP;
    end else if (is_rel && rd_free) begin
      st_next = ST_REL_FREE;
    end else begin
      st_next = ST_OK;
    end

    wr.cmd_we    = (is_rel && !rd_free) || is_add;
    wr.cmd_idx   = obj_q;
    wr.live_new  = is_add ? (live_sum[COUNT_BITS] ? '1 : live_sum[COUNT_BITS-1:0])
                          : live_dec;
    wr.allow_we  = v_q && (cmd_q == CMD_ENABLE || cmd_q == CMD_DISABLE);
    wr.allow_val = (cmd_q == CMD_ENABLE);
    wr.set_free  = push_free;
    wr.grant_we  = grant;
    wr.grant_idx = g_obj;

    free_op.push = push_free;
    free_op.pop  = grant;
    free_op.val  = obj_q;
    wait_op.push = push_wait;
    wait_op.pop  = grant;
    wait_op.val  = pid_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_q;
    end
    grant_valid   <= grant;
    grant_object  <= grant ? g_obj : '0;
    grant_process <= grant ? g_pid : '0;
    status        <= st_next;
  end

  `RBPA_ASSERT_NEXT(done_latency, start && !busy, ##1 done)
  `RBPA_ASSERT(done_origin, done, $past(start, 2))
  `RBPA_ASSERT(flag_without_grant, done && status != ST_OK, !grant_valid)
endmodule

// ===== dv/refcounted_buffer_pool_allocator_test.sv =====
// Self-checking testbench of the buffer pool allocator: directed and random commands.
`timescale 1ns / 100ps

module refcounted_buffer_pool_allocator_test;
  import rbpa_pkg::*;

  localparam int CMD_CODES    = 1 << CMD_W;
  localparam int RANDOM_ITEMS = 800;
  localparam int SAT_ADDS     = 260;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic             grant_valid;
    logic [OBJ_W-1:0] grant_object;
    logic [PID_W-1:0] grant_process;
    status_t          status;
  } grant_outcome_t;

  class pool_scoreboard;
    logic [OBJ_W-1:0]      free_ring [OBJECTS];
    int                    free_head;
    int                    free_count;
    logic [PID_W-1:0]      waiter_ring [PROCESSES];
    int                    waiter_head;
    int                    waiter_count;
    logic [COUNT_BITS-1:0] live_count [OBJECTS];
    bit                    release_allowed [OBJECTS];
    bit                    is_free [OBJECTS];
    grant_outcome_t        awaited_outcomes [$];
    int                    errors;

    function new();
      for (int i = 0; i < OBJECTS; i++) begin
        free_ring[i]       = OBJ_W'(i);
        live_count[i]      = '0;
        release_allowed[i] = 1'b1;
        is_free[i]         = 1'b1;
      end
      for (int i = 0; i < PROCESSES; i++) waiter_ring[i] = '0;
      free_head    = 0;
      free_count   = OBJECTS;
      waiter_head  = 0;
      waiter_count = 0;
      errors       = 0;
    endfunction

    // apply one accepted request to the pool state and queue its outcome
    function void note_command(cmd_t op, logic [PID_W-1:0] pid, logic [OBJ_W-1:0] obj,
                               logic [AMT_W-1:0] amt);
      grant_outcome_t      res;
      logic [COUNT_BITS:0] sum;
      logic [OBJ_W-1:0]    granted;
      res = '0;
      res.status = ST_OK;
      case (op)
        CMD_REQ: begin
          if (waiter_count >= PROCESSES) begin
            res.status = ST_DROP;
          end else begin
            waiter_head = (waiter_head + PROCESSES - 1) % PROCESSES;
            waiter_ring[waiter_head] = pid;
            waiter_count++;
          end
        end
        CMD_REL: begin
          if (is_free[obj]) begin
            res.status = ST_REL_FREE;
          end else begin
            if (live_count[obj] != '0) live_count[obj] = live_count[obj] - 1'b1;
            if (release_allowed[obj] && live_count[obj] == '0 && free_count < OBJECTS) begin
              is_free[obj] = 1'b1;
              free_head = (free_head + OBJECTS - 1) % OBJECTS;
              free_ring[free_head] = obj;
              free_count++;
            end
          end
        end
        CMD_ADD: begin
          sum = {1'b0, live_count[obj]} + amt;
          live_count[obj] = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
        end
        CMD_ENABLE:  release_allowed[obj] = 1'b1;
        CMD_DISABLE: release_allowed[obj] = 1'b0;
        default: ;
      endcase
      if (free_count != 0 && waiter_count != 0) begin
        granted = free_ring[free_head];
        res.grant_valid   = 1'b1;
        res.grant_object  = granted;
        res.grant_process = waiter_ring[waiter_head];
        waiter_head = (waiter_head + 1) % PROCESSES;
        waiter_count--;
        free_head = (free_head + 1) % OBJECTS;
        free_count--;
        live_count[granted]      = '0;
        release_allowed[granted] = 1'b1;
        is_free[granted]         = 1'b0;
      end
      awaited_outcomes.push_back(res);
    endfunction

    function void check_outcome(grant_outcome_t got);
      grant_outcome_t want;
      if (awaited_outcomes.size() == 0) begin
        $error("result strobe with no request outstanding");
        errors++;
        return;
      end
      want = awaited_outcomes.pop_front();
      if (got.grant_valid !== want.grant_valid) begin
        $error("grant_valid expected %0d actual %0d", want.grant_valid, got.grant_valid);
        errors++;
      end
      if (got.grant_object !== want.grant_object) begin
        $error("grant_object expected %0d actual %0d", want.grant_object, got.grant_object);
        errors++;
      end
      if (got.grant_process !== want.grant_process) begin
        $error("grant_process expected %0d actual %0d", want.grant_process,
               got.grant_process);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        errors++;
      end
    endfunction

    function int outstanding();
      return awaited_outcomes.size();
    endfunction

    // random object currently handed out, -1 if none
    function int held_object();
      int picks [$];
      for (int i = 0; i < OBJECTS; i++) if (!is_free[i]) picks.push_back(i);
      if (picks.size() == 0) return -1;
      return picks[$urandom_range(picks.size() - 1)];
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [CMD_W-1:0]   cmd;
  logic [PID_W-1:0]   process_id;
  logic [OBJ_W-1:0]   object_id;
  logic [AMT_W-1:0]   amount;
  logic               done;
  logic               grant_valid;
  logic [OBJ_W-1:0]   grant_object;
  logic [PID_W-1:0]   grant_process;
  logic [STAT_W-1:0]  status;

  pool_scoreboard pool;
  int             idle_pct;
  int             sent;
  int             cycles = 0;

  refcounted_buffer_pool_allocator u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cmd           (cmd),
    .process_id    (process_id),
    .object_id     (object_id),
    .amount        (amount),
    .done          (done),
    .grant_valid   (grant_valid),
    .grant_object  (grant_object),
    .grant_process (grant_process),
    .status        (status)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL refcounted_buffer_pool_allocator");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done)
      pool.check_outcome('{grant_valid, grant_object, grant_process, status_t'(status)});
  end

  task automatic issue(input logic [CMD_W-1:0] op, input logic [PID_W-1:0] pid,
                       input logic [OBJ_W-1:0] obj, input logic [AMT_W-1:0] amt);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    cmd        <= op;
    process_id <= pid;
    object_id  <= obj;
    amount     <= amt;
    @(posedge clk);
    while (busy) @(posedge clk);
    pool.note_command(cmd_t'(op), pid, obj, amt);
    sent++;
  endtask

  task automatic request(input logic [PID_W-1:0] pid);
    issue(CMD_REQ, pid, OBJ_W'($urandom), AMT_W'($urandom));
  endtask

  task automatic on_object(input cmd_t op, input logic [OBJ_W-1:0] obj,
                           input logic [AMT_W-1:0] amt);
    issue(op, PID_W'($urandom), obj, amt);
  endtask

  task automatic saturate_one();
    int obj;
    while (pool.held_object() < 0) request(PID_W'($urandom));
    obj = pool.held_object();
    on_object(CMD_DISABLE, OBJ_W'(obj), '0);
    repeat (SAT_ADDS) on_object(CMD_ADD, OBJ_W'(obj), '1);
    on_object(CMD_ADD, OBJ_W'(obj), '0);
    on_object(CMD_REL, OBJ_W'(obj), '0);
    on_object(CMD_ENABLE, OBJ_W'(obj), '0);
    on_object(CMD_REL, OBJ_W'(obj), '0);
  endtask

  initial begin
    int  kind;
    int  obj;
    int  n;
    int  base;
    bit  saturated;
    pool       = new();
    rst        = 1'b1;
    start      = 1'b0;
    cmd        = '0;
    process_id = '0;
    object_id  = '0;
    amount     = '0;
    idle_pct   = 0;
    sent       = 0;
    saturated  = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed
    on_object(CMD_REL, 4'd3, '0);
    on_object(CMD_REL, 4'd15, '1);
    on_object(CMD_ADD, 4'd5, '1);
    on_object(CMD_ADD, 4'd2, '0);
    on_object(CMD_DISABLE, 4'd5, '0);
    issue(CMD_W'(CMD_CODES - 3), '0, '0, '0);
    issue(CMD_W'(CMD_CODES - 2), '1, '0, '1);
    issue(CMD_W'(CMD_CODES - 1), '1, '1, '1);
    request('1);
    request('0);
    on_object(CMD_ADD, 4'd0, 8'd2);
    on_object(CMD_REL, 4'd0, '0);
    on_object(CMD_REL, 4'd0, '0);
    request(3'd3);
    on_object(CMD_DISABLE, 4'd1, '0);
    on_object(CMD_REL, 4'd1, '0);
    on_object(CMD_ENABLE, 4'd1, '0);
    on_object(CMD_REL, 4'd1, '0);
    on_object(CMD_REL, 4'd1, '0);

    // random, in three idling phases
    base = sent;
    while (sent - base < RANDOM_ITEMS) begin
      n = sent - base;
      idle_pct = (n < RANDOM_ITEMS / 3) ? 24 : (n < 2 * RANDOM_ITEMS / 3) ? 84 : 0;
      if (!saturated && n >= 2 * RANDOM_ITEMS / 3) begin
        saturated = 1'b1;
        saturate_one();
      end
      kind = $urandom_range(99);
      if (kind < 30) begin
        repeat ($urandom_range(1, 12)) request(PID_W'($urandom));
      end else if (kind < 60) begin
        obj = pool.held_object();
        if (obj < 0) begin
          request(PID_W'($urandom));
        end else begin
          n = $urandom_range(0, 3);
          on_object(CMD_ADD, OBJ_W'(obj), AMT_W'(n));
          if ($urandom_range(3) == 0) on_object(CMD_DISABLE, OBJ_W'(obj), '0);
          repeat (n + 1) on_object(CMD_REL, OBJ_W'(obj), AMT_W'($urandom));
          if ($urandom_range(1) == 0) on_object(CMD_ENABLE, OBJ_W'(obj), '0);
          on_object(CMD_REL, OBJ_W'(obj), AMT_W'($urandom));
        end
      end else if (kind < 75) begin
        repeat ($urandom_range(1, 6)) begin
          obj = pool.held_object();
          if (obj < 0) obj = $urandom_range(OBJECTS - 1);
          on_object(CMD_REL, OBJ_W'(obj), AMT_W'($urandom));
        end
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 4))
          on_object($urandom_range(1) ? CMD_ENABLE : CMD_DISABLE, OBJ_W'($urandom),
                    AMT_W'($urandom));
      end else begin
        repeat ($urandom_range(1, 5))
          issue(CMD_W'($urandom), PID_W'($urandom), OBJ_W'($urandom), AMT_W'($urandom));
      end
    end

    start <= 1'b0;
    while (pool.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pool.errors == 0 && pool.outstanding() == 0) begin
      $display("PASS refcounted_buffer_pool_allocator");
    end else begin
      $display("FAIL refcounted_buffer_pool_allocator");
    end
    $finish;
  end

endmodule
